FILE: rtl/cabdd_pkg.sv
// Shared types and constants for the cabinet data block deframer.
`timescale 1ns / 1ps
package cabdd_pkg;

  localparam int MAX_PACKED = 65536;

  localparam logic [15:0] FULL_BLOCK_SIZE_RESET = 16'd32768;
  localparam logic [7:0]  RESERVED_BYTES_RESET  = 8'd0;

  localparam logic [0:0] CFG_RESERVED_BYTES  = 1'b0;
  localparam logic [0:0] CFG_FULL_BLOCK_SIZE = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_OVERFLOW,
    ERR_CHECKSUM,
    ERR_UNPACKED
  } err_t;

  typedef struct packed {
    logic [7:0]  reserved_bytes;
    logic [15:0] full_block_size;
  } cfg_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        block_done;
    logic [15:0] unpacked_size;
    logic [16:0] packed_size;
    err_t        error_code;
  } result_t;

endpackage

FILE: rtl/cab_data_block_deframer_core.sv
// Top level of the cabinet data block deframer: config registers, parser, result buffer.
`timescale 1ns / 1ps
// Takes one byte of a folder's data record stream per clock while in_stall is low, and
// returns at most one word per byte: a passed-through payload byte, a block end with its
// sizes, or an error code. The parser is a single registered pass, so a byte can be
// accepted every cycle; the output register plus one skid entry let input continue while
// the output is stalled, and in_stall rises only when both are full. After an error the
// block drops all bytes until a byte with folder_start set. Payload bytes leave before
// the record's checksum is known, so the consumer discards a block when an error word
// follows. MAX_PACKED bounds the packed bytes gathered for one logical block.
module cab_data_block_deframer_core #(
  parameter int MAX_PACKED = cabdd_pkg::MAX_PACKED
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        folder_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic        block_done,
  output logic [15:0] unpacked_size,
  output logic [16:0] packed_size,
  output logic [1:0]  error_code
);
  import cabdd_pkg::*;

  cfg_t    cfg;
  result_t res, res_out;
  logic    res_push;
  logic    accept;
  logic    full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reserved_bytes  <= RESERVED_BYTES_RESET;
      cfg.full_block_size <= FULL_BLOCK_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESERVED_BYTES:  cfg.reserved_bytes  <= cfg_data[7:0];
        CFG_FULL_BLOCK_SIZE: cfg.full_block_size <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  cabdd_parse #(
    .MAX_PACKED (MAX_PACKED)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .folder_start (folder_start),
    .cfg          (cfg),
    .res_push     (res_push),
    .res          (res)
  );

  cabdd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_push),
    .res_in    (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_out)
  );

  assign payload_valid = res_out.payload_valid;
  assign payload_byte  = res_out.payload_byte;
  assign block_done    = res_out.block_done;
  assign unpacked_size = res_out.unpacked_size;
  assign packed_size   = res_out.packed_size;
  assign error_code    = res_out.error_code;

endmodule

FILE: rtl/cabdd_parse.sv
// Record parser, checksum folding and block checks, one byte per accept.
`timescale 1ns / 1ps
module cabdd_parse #(
  parameter int MAX_PACKED = cabdd_pkg::MAX_PACKED
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              folder_start,
  input  cabdd_pkg::cfg_t   cfg,
  output logic              res_push,
  output cabdd_pkg::result_t res
);
  import cabdd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_HALTED
  } phase_t;

  localparam logic [17:0] MAX_PACKED_18 = 18'(MAX_PACKED);

  phase_t      phase, phase_next, phase_in;
  logic [8:0]  header_count, header_count_next;
  logic [31:0] stored_sum, stored_sum_next;
  logic [15:0] record_packed, record_packed_next;
  logic [15:0] record_unpacked, record_unpacked_next;
  logic [15:0] payload_left, payload_left_next;
  logic [31:0] header_sum, header_sum_next;
  logic [31:0] payload_sum, payload_sum_next;
  logic [23:0] partial_word, partial_word_next;
  logic [1:0]  partial_count, partial_count_next;
  logic [16:0] packed_total, packed_total_next;
  logic        short_seen, short_seen_next;

  logic [8:0]  pos;
  logic [16:0] pt_in;
  logic        short_in;
  logic        pos_zero;
  logic [31:0] ss_base, hs_base;
  logic [15:0] rp_base, ru_base;
  logic [23:0] pw_base;
  logic [1:0]  pc_base;

  logic [31:0] ab_sum_in, ab_sum, ab_word;
  logic [23:0] ab_pw_in, ab_pw;
  logic [1:0]  ab_pc_in, ab_pc;

  logic [31:0] ss_hdr, hs_hdr, hs_fin, ps_fin;
  logic [15:0] rp_hdr, ru_hdr, pl_dec;
  logic [23:0] pw_hdr;
  logic [1:0]  pc_hdr;
  logic [8:0]  hdr_len;
  logic [9:0]  pos_inc;
  logic        hdr_end;
  logic        overflow;

  logic [31:0] cl_hs, cl_ps, cl_ss;
  logic [15:0] cl_rp, cl_ru;
  logic [16:0] cl_pt;
  logic        cl_sum_bad, cl_size_bad;

  assign phase_in = folder_start ? PH_HEADER : phase;
  assign pos      = folder_start ? 9'd0 : header_count;
  assign pt_in    = folder_start ? 17'd0 : packed_total;
  assign short_in = folder_start ? 1'b0 : short_seen;

  assign pos_zero = (pos == 9'd0);
  assign ss_base  = pos_zero ? 32'd0 : stored_sum;
  assign hs_base  = pos_zero ? 32'd0 : header_sum;
  assign rp_base  = pos_zero ? 16'd0 : record_packed;
  assign ru_base  = pos_zero ? 16'd0 : record_unpacked;
  assign pw_base  = pos_zero ? 24'd0 : partial_word;
  assign pc_base  = pos_zero ? 2'd0 : partial_count;

  // Shared fold unit: header bytes in header phase, payload bytes otherwise.
  assign ab_sum_in = (phase_in == PH_HEADER) ? hs_base : payload_sum;
  assign ab_pw_in  = (phase_in == PH_HEADER) ? pw_base : partial_word;
  assign ab_pc_in  = (phase_in == PH_HEADER) ? pc_base : partial_count;
  assign ab_word   = {data_byte, ab_pw_in[7:0], ab_pw_in[15:8], ab_pw_in[23:16]};

  always_comb begin
    if (ab_pc_in == 2'd3) begin
      ab_sum = ab_sum_in ^ ab_word;
      ab_pw  = 24'd0;
      ab_pc  = 2'd0;
    end else begin
      ab_sum = ab_sum_in;
      ab_pw  = {ab_pw_in[15:0], data_byte};
      ab_pc  = ab_pc_in + 2'd1;
    end
  end

  always_comb begin
    ss_hdr = ss_base;
    hs_hdr = hs_base;
    pw_hdr = pw_base;
    pc_hdr = pc_base;
    rp_hdr = rp_base;
    ru_hdr = ru_base;
    if (pos < 9'd4) begin
      case (pos[1:0])
        2'd0: ss_hdr[7:0]   = data_byte;
        2'd1: ss_hdr[15:8]  = data_byte;
        2'd2: ss_hdr[23:16] = data_byte;
        default: ss_hdr[31:24] = data_byte;
      endcase
    end else begin
      hs_hdr = ab_sum;
      pw_hdr = ab_pw;
      pc_hdr = ab_pc;
      if (pos == 9'd4) begin
        rp_hdr = {8'd0, data_byte};
      end else if (pos == 9'd5) begin
        rp_hdr = {data_byte, rp_base[7:0]};
      end else if (pos == 9'd6) begin
        ru_hdr = {8'd0, data_byte};
      end else if (pos == 9'd7) begin
        ru_hdr = {data_byte, ru_base[7:0]};
      end
    end
  end

  assign hdr_len  = 9'd8 + {1'b0, cfg.reserved_bytes};
  assign pos_inc  = {1'b0, pos} + 10'd1;
  assign hdr_end  = (pos_inc >= {1'b0, hdr_len});
  assign hs_fin   = hs_hdr ^ {8'd0, pw_hdr};
  assign overflow = ({2'b0, rp_hdr} + {1'b0, pt_in}) > MAX_PACKED_18;
  assign pl_dec   = payload_left - 16'd1;
  assign ps_fin   = ab_sum ^ {8'd0, ab_pw};

  // Record close checks, fed from the header path or the payload path.
  always_comb begin
    if (phase_in == PH_HEADER) begin
      cl_hs = hs_fin;
      cl_ps = 32'd0;
      cl_ss = ss_hdr;
      cl_rp = rp_hdr;
      cl_ru = ru_hdr;
    end else begin
      cl_hs = header_sum;
      cl_ps = ps_fin;
      cl_ss = stored_sum;
      cl_rp = record_packed;
      cl_ru = record_unpacked;
    end
  end

  assign cl_sum_bad  = (cl_ss != 32'd0) && ((cl_hs ^ cl_ps) != cl_ss);
  assign cl_pt       = pt_in + {1'b0, cl_rp};
  assign cl_size_bad = (cl_ru > cfg.full_block_size) || short_in;

  always_comb begin
    phase_next           = phase_in;
    header_count_next    = pos;
    stored_sum_next      = stored_sum;
    record_packed_next   = record_packed;
    record_unpacked_next = record_unpacked;
    payload_left_next    = payload_left;
    header_sum_next      = header_sum;
    payload_sum_next     = payload_sum;
    partial_word_next    = partial_word;
    partial_count_next   = partial_count;
    packed_total_next    = pt_in;
    short_seen_next      = short_in;
    res                  = '0;
    res_push             = 1'b0;
    unique case (phase_in)
      PH_HEADER: begin
        stored_sum_next      = ss_hdr;
        record_packed_next   = rp_hdr;
        record_unpacked_next = ru_hdr;
        header_sum_next      = hs_hdr;
        partial_word_next    = pw_hdr;
        partial_count_next   = pc_hdr;
        if (!hdr_end) begin
          header_count_next = pos_inc[8:0];
        end else begin
          header_count_next  = 9'd0;
          header_sum_next    = hs_fin;
          partial_word_next  = 24'd0;
          partial_count_next = 2'd0;
          payload_sum_next   = 32'd0;
          if (overflow) begin
            res_push       = 1'b1;
            res.error_code = ERR_OVERFLOW;
            phase_next     = PH_HALTED;
          end else if (rp_hdr != 16'd0) begin
            payload_left_next = rp_hdr;
            phase_next        = PH_PAYLOAD;
          end else if (cl_sum_bad) begin
            res_push       = 1'b1;
            res.error_code = ERR_CHECKSUM;
            phase_next     = PH_HALTED;
          end else begin
            packed_total_next = cl_pt;
            if (cl_ru != 16'd0) begin
              res_push = 1'b1;
              if (cl_size_bad) begin
                res.error_code = ERR_UNPACKED;
                phase_next     = PH_HALTED;
              end else begin
                short_seen_next   = short_in | (cl_ru != cfg.full_block_size);
                res.block_done    = 1'b1;
                res.unpacked_size = cl_ru;
                res.packed_size   = cl_pt;
                packed_total_next = 17'd0;
              end
            end
          end
        end
      end
      PH_PAYLOAD: begin
        res_push           = 1'b1;
        res.payload_valid  = 1'b1;
        res.payload_byte   = data_byte;
        payload_sum_next   = ab_sum;
        partial_word_next  = ab_pw;
        partial_count_next = ab_pc;
        payload_left_next  = pl_dec;
        if (pl_dec == 16'd0) begin
          payload_sum_next   = ps_fin;
          partial_word_next  = 24'd0;
          partial_count_next = 2'd0;
          if (cl_sum_bad) begin
            res.error_code = ERR_CHECKSUM;
            phase_next     = PH_HALTED;
          end else begin
            packed_total_next = cl_pt;
            phase_next        = PH_HEADER;
            if (cl_ru != 16'd0) begin
              if (cl_size_bad) begin
                res.error_code = ERR_UNPACKED;
                phase_next     = PH_HALTED;
              end else begin
                short_seen_next   = short_in | (cl_ru != cfg.full_block_size);
                res.block_done    = 1'b1;
                res.unpacked_size = cl_ru;
                res.packed_size   = cl_pt;
                packed_total_next = 17'd0;
              end
            end
          end
        end
      end
      PH_HALTED: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_count <= 9'd0;
      packed_total <= 17'd0;
      short_seen   <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      stored_sum      <= stored_sum_next;
      record_packed   <= record_packed_next;
      record_unpacked <= record_unpacked_next;
      payload_left    <= payload_left_next;
      header_sum      <= header_sum_next;
      payload_sum     <= payload_sum_next;
      partial_word    <= partial_word_next;
      partial_count   <= partial_count_next;
      packed_total    <= packed_total_next;
      short_seen      <= short_seen_next;
    end
  end

endmodule

FILE: rtl/cabdd_out_buf.sv
// Result register with one skid entry between the parser and the output channel.
`timescale 1ns / 1ps
module cabdd_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cabdd_pkg::result_t res_in,
  output logic               full,
  output logic               out_valid,
  input  logic               out_stall,
  output cabdd_pkg::result_t res_out
);
  import cabdd_pkg::*;

  result_t skid;
  logic    skid_valid;
  logic    out_fire;

  assign out_fire = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        res_out    <= skid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_fire) begin
        res_out   <= res_in;
        out_valid <= 1'b1;
      end else begin
        skid       <= res_in;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/cabdd_checker.sv
// Port-level checks for the cabinet data block deframer, bound to the top level.
`timescale 1ns / 1ps
module cabdd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        payload_valid,
  input logic [7:0]  payload_byte,
  input logic        block_done,
  input logic [15:0] unpacked_size,
  input logic [16:0] packed_size,
  input logic [1:0]  error_code
);
  import cabdd_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(payload_byte) && $stable(error_code))
    else $error("output word changed while stalled");

  a_done_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_done |-> error_code == ERR_NONE)
    else $error("block end reported together with an error");

  a_word_meaning: assert property (@(posedge clk) disable iff (rst)
    out_valid && !payload_valid && !block_done |-> error_code != ERR_NONE)
    else $error("output word carries nothing");

  a_sizes_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !block_done |-> unpacked_size == 16'd0 && packed_size == 17'd0)
    else $error("sizes set without block end");

  a_payload_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && block_done |-> packed_size <= 17'(MAX_PACKED))
    else $error("packed size above limit");

endmodule

bind cab_data_block_deframer_core cabdd_checker u_cabdd_checker (.*);
